// ===== rtl/core/rsg_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, register indexes and the quarter-wave sine table
// for the radial sine gradient pixel block; no dependencies
package rsg_pkg;

    localparam int COL_W     = 10;
    localparam int INT_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int SIN_W     = 17;
    localparam int TIDX_W    = 6;
    localparam int TFRAC_W   = 10;
    localparam int MAX_SIZE_DEF = 1024;

    localparam logic [CFG_W-1:0] TEX_SIZE_RST = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = CFG_IDX_W'(1);

    function automatic logic [SIN_W-1:0] quarter_sine(input logic [TIDX_W-1:0] idx);
        logic [SIN_W-1:0] v;
        unique case (idx)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd3216;
            6'd2:  v = 17'd6424;
            6'd3:  v = 17'd9616;
            6'd4:  v = 17'd12785;
            6'd5:  v = 17'd15924;
            6'd6:  v = 17'd19024;
            6'd7:  v = 17'd22078;
            6'd8:  v = 17'd25080;
            6'd9:  v = 17'd28020;
            6'd10: v = 17'd30893;
            6'd11: v = 17'd33692;
            6'd12: v = 17'd36410;
            6'd13: v = 17'd39040;
            6'd14: v = 17'd41576;
            6'd15: v = 17'd44011;
            6'd16: v = 17'd46341;
            6'd17: v = 17'd48559;
            6'd18: v = 17'd50660;
            6'd19: v = 17'd52639;
            6'd20: v = 17'd54491;
            6'd21: v = 17'd56212;
            6'd22: v = 17'd57798;
            6'd23: v = 17'd59244;
            6'd24: v = 17'd60547;
            6'd25: v = 17'd61705;
            6'd26: v = 17'd62714;
            6'd27: v = 17'd63572;
            6'd28: v = 17'd64277;
            6'd29: v = 17'd64827;
            6'd30: v = 17'd65220;
            6'd31: v = 17'd65457;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rsg_sqrt_cell.sv =====
`timescale 1ns / 1ps
// one digit cell of the square root chain, two lanes (pixel and corner)
// depends on nothing but its parameters
module rsg_sqrt_cell #(
    parameter int RW = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad_a,
    input  logic [RW+1:0]   i_rem_a,
    input  logic [RW-1:0]   i_root_a,
    input  logic [2*RW-1:0] i_rad_b,
    input  logic [RW+1:0]   i_rem_b,
    input  logic [RW-1:0]   i_root_b,
    output logic            o_valid,
    output logic [2*RW-1:0] o_rad_a,
    output logic [RW+1:0]   o_rem_a,
    output logic [RW-1:0]   o_root_a,
    output logic [2*RW-1:0] o_rad_b,
    output logic [RW+1:0]   o_rem_b,
    output logic [RW-1:0]   o_root_b
);

    localparam int SW = 2*RW + RW + 2 + RW;

    function automatic logic [SW-1:0] step(input logic [2*RW-1:0] rad,
                                           input logic [RW+1:0] rem,
                                           input logic [RW-1:0] root);
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;
        cur   = {rem, rad[2*RW-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        diff  = cur - trial;
        ge    = (cur >= trial);
        return {rad[2*RW-3:0], 2'b00,
                ge ? diff[RW+1:0] : cur[RW+1:0],
                root[RW-2:0], ge};
    endfunction

    logic            r_valid;
    logic [SW-1:0]   r_a, r_b;
    logic [SW-1:0]   n_a, n_b;

    always_comb begin
        n_a = step(i_rad_a, i_rem_a, i_root_a);
        n_b = step(i_rad_b, i_rem_b, i_root_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_valid  = r_valid;
    assign o_rad_a  = r_a[SW-1 -: 2*RW];
    assign o_rem_a  = r_a[2*RW+1 -: RW+2];
    assign o_root_a = r_a[RW-1:0];
    assign o_rad_b  = r_b[SW-1 -: 2*RW];
    assign o_rem_b  = r_b[2*RW+1 -: RW+2];
    assign o_root_b = r_b[RW-1:0];

endmodule

// ===== rtl/core/rsg_div_cell.sv =====
`timescale 1ns / 1ps
// one quotient bit cell of the restoring divider chain
// uses rsg_pkg for the fraction width
module rsg_div_cell #(
    parameter int RW = 19
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_over,
    input  logic [RW-1:0]             i_dmax,
    input  logic [RW:0]               i_rem,
    input  logic [rsg_pkg::FRAC_W-1:0] i_quo,
    output logic                      o_valid,
    output logic                      o_over,
    output logic [RW-1:0]             o_dmax,
    output logic [RW:0]               o_rem,
    output logic [rsg_pkg::FRAC_W-1:0] o_quo
);

    import rsg_pkg::*;

    logic              r_valid, r_over;
    logic [RW-1:0]     r_dmax;
    logic [RW:0]       r_rem, n_rem;
    logic [FRAC_W-1:0] r_quo, n_quo;
    logic [RW+1:0]     sh;
    logic              ge;

    always_comb begin
        sh    = {i_rem, 1'b0};
        ge    = (sh >= {2'b00, i_dmax});
        n_rem = ge ? (RW+1)'(sh - {2'b00, i_dmax}) : sh[RW:0];
        n_quo = {i_quo[FRAC_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_over <= i_over;
            r_dmax <= i_dmax;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_over  = r_over;
    assign o_dmax  = r_dmax;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

// ===== rtl/core/rsg_sine.sv =====
`timescale 1ns / 1ps
// quarter-wave sine lookup with linear interpolation, clamp and output register
// uses rsg_pkg for the table and widths
module rsg_sine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_over,
    input  logic [rsg_pkg::FRAC_W-1:0] i_ratio,
    output logic                       o_valid,
    output logic [rsg_pkg::INT_W-1:0]  o_intensity
);

    import rsg_pkg::*;

    logic               r_a_valid, r_a_zero;
    logic [SIN_W-1:0]   r_lo, r_hi;
    logic [TFRAC_W-1:0] r_frac;
    logic               r_valid;
    logic [INT_W-1:0]   r_int;

    logic [FRAC_W:0]    q17;
    logic [FRAC_W-1:0]  q;
    logic [TIDX_W-1:0]  idx, idx1;
    logic [SIN_W-1:0]   n_lo, n_hi;

    logic [SIN_W+TFRAC_W-1:0] prod;
    logic [SIN_W:0]           s;
    logic [INT_W:0]           s8;
    logic [INT_W-1:0]         n_int;

    always_comb begin
        q17  = i_ratio[FRAC_W-1] ? (17'h10000 - {1'b0, i_ratio}) : {1'b0, i_ratio};
        q    = q17[FRAC_W-1:0];
        idx  = q[FRAC_W-1 -: TIDX_W];
        idx1 = idx[TIDX_W-1] ? idx : idx + TIDX_W'(1);
        n_lo = quarter_sine(idx);
        n_hi = quarter_sine(idx1);
    end

    always_comb begin
        prod  = (r_hi - r_lo) * r_frac;
        s     = {1'b0, r_lo} + (SIN_W+1)'(prod >> TFRAC_W);
        s8    = s[INT_W+8:8];
        n_int = r_a_zero ? '0 : (s8[INT_W] ? '1 : s8[INT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= i_over;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_frac   <= q[TFRAC_W-1:0];
            r_int    <= n_int;
        end
    end

    assign o_valid     = r_valid;
    assign o_intensity = r_int;

endmodule

// ===== rtl/core/radial_sine_gradient_pixel_top.sv =====
`timescale 1ns / 1ps
// Radial sine gradient pixel generator: one pixel beat in, one intensity beat
// out, one beat per clock sustained while the output is not stalled. RW is the
// root width (19 at MAX_SIZE 1024). Offset and square registers feed a chain of
// square root digit cells, one per root bit, 16 divider cells, one per ratio bit,
// and the sine registers; all advance together, holding while the output is stalled.
// depends on rsg_pkg, rsg_sqrt_cell, rsg_div_cell, rsg_sine
module radial_sine_gradient_pixel_top #(
    parameter int MAX_SIZE = rsg_pkg::MAX_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rsg_pkg::COL_W-1:0]     i_col,
    input  logic [rsg_pkg::COL_W-1:0]     i_row,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rsg_pkg::INT_W-1:0]     o_intensity,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rsg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rsg_pkg::CFG_W-1:0]     i_cfg_data
);

    import rsg_pkg::*;

    localparam int MS_W  = ($clog2(MAX_SIZE + 1) > CFG_W) ? $clog2(MAX_SIZE + 1) : CFG_W;
    localparam int HW    = $clog2(MAX_SIZE / 2 + 1);
    localparam int DW    = (HW > COL_W) ? HW : COL_W;
    localparam int SQW   = 2 * DW + 1;
    localparam int RW    = (SQW + FRAC_W + 1) / 2;

    logic [CFG_W-1:0] r_tex_width, r_tex_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= TEX_SIZE_RST;
            r_tex_height <= TEX_SIZE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TEX_WIDTH) begin
                r_tex_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_TEX_HEIGHT) begin
                r_tex_height <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // centre and offsets
    logic [MS_W-1:0] w_ext, h_ext, w_clip, h_clip;
    logic [DW-1:0]   mx, my, cx, cy, n_dx, n_dy;

    always_comb begin
        w_ext  = MS_W'(r_tex_width);
        h_ext  = MS_W'(r_tex_height);
        w_clip = (w_ext > MS_W'(MAX_SIZE)) ? MS_W'(MAX_SIZE) : w_ext;
        h_clip = (h_ext > MS_W'(MAX_SIZE)) ? MS_W'(MAX_SIZE) : h_ext;
        mx     = DW'(w_clip >> 1);
        my     = DW'(h_clip >> 1);
        cx     = DW'(i_col);
        cy     = DW'(i_row);
        n_dx   = (cx >= mx) ? cx - mx : mx - cx;
        n_dy   = (cy >= my) ? cy - my : my - cy;
    end

    logic            r_s0_valid, r_s1_valid;
    logic [DW-1:0]   r_dx, r_dy, r_mx, r_my;
    logic [SQW-1:0]  r_sq_a, r_sq_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_mx   <= mx;
            r_my   <= my;
            r_sq_a <= SQW'(r_dx) * SQW'(r_dx) + SQW'(r_dy) * SQW'(r_dy);
            r_sq_b <= SQW'(r_mx) * SQW'(r_mx) + SQW'(r_my) * SQW'(r_my);
        end
    end

    // square root chain
    logic            sq_v     [0:RW];
    logic [2*RW-1:0] rad_a    [0:RW];
    logic [RW+1:0]   rem_a    [0:RW];
    logic [RW-1:0]   root_a   [0:RW];
    logic [2*RW-1:0] rad_b    [0:RW];
    logic [RW+1:0]   rem_b    [0:RW];
    logic [RW-1:0]   root_b   [0:RW];

    assign sq_v[0]   = r_s1_valid;
    assign rad_a[0]  = (2*RW)'({r_sq_a, {FRAC_W{1'b0}}});
    assign rad_b[0]  = (2*RW)'({r_sq_b, {FRAC_W{1'b0}}});
    assign rem_a[0]  = '0;
    assign rem_b[0]  = '0;
    assign root_a[0] = '0;
    assign root_b[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        rsg_sqrt_cell #(.RW(RW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (sq_v[k]),
            .i_rad_a  (rad_a[k]),
            .i_rem_a  (rem_a[k]),
            .i_root_a (root_a[k]),
            .i_rad_b  (rad_b[k]),
            .i_rem_b  (rem_b[k]),
            .i_root_b (root_b[k]),
            .o_valid  (sq_v[k+1]),
            .o_rad_a  (rad_a[k+1]),
            .o_rem_a  (rem_a[k+1]),
            .o_root_a (root_a[k+1]),
            .o_rad_b  (rad_b[k+1]),
            .o_rem_b  (rem_b[k+1]),
            .o_root_b (root_b[k+1])
        );
    end

    // divider chain
    logic              dv_v    [0:FRAC_W];
    logic              dv_over [0:FRAC_W];
    logic [RW-1:0]     dv_dmax [0:FRAC_W];
    logic [RW:0]       dv_rem  [0:FRAC_W];
    logic [FRAC_W-1:0] dv_quo  [0:FRAC_W];

    assign dv_v[0]    = sq_v[RW];
    assign dv_over[0] = (root_a[RW] >= root_b[RW]);
    assign dv_dmax[0] = root_b[RW];
    assign dv_rem[0]  = {1'b0, root_a[RW]};
    assign dv_quo[0]  = '0;

    for (genvar k = 0; k < FRAC_W; k++) begin : g_div
        rsg_div_cell #(.RW(RW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[k]),
            .i_over  (dv_over[k]),
            .i_dmax  (dv_dmax[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .o_valid (dv_v[k+1]),
            .o_over  (dv_over[k+1]),
            .o_dmax  (dv_dmax[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    rsg_sine u_sine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (dv_v[FRAC_W]),
        .i_over      (dv_over[FRAC_W]),
        .i_ratio     (dv_quo[FRAC_W]),
        .o_valid     (o_valid),
        .o_intensity (o_intensity)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for radial_sine_gradient_pixel_top: a queued pixel driver,
// a bit-accurate intensity predictor and an output monitor, run across several texture sizes
// depends on rsg_pkg and the radial_sine_gradient_pixel_top rtl
module testbench;
    import rsg_pkg::*;

    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [COL_W-1:0]     i_col = '0;
    logic [COL_W-1:0]     i_row = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [INT_W-1:0]     o_intensity;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TEX_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    t_pixel           pixel_q[$];
    logic [INT_W-1:0] intensity_q[$];
    logic [CFG_W-1:0] tex_w = TEX_SIZE_RST;
    logic [CFG_W-1:0] tex_h = TEX_SIZE_RST;
    logic             in_fired = 1'b0;
    int               mismatches = 0;
    int               gap_left = 0;
    int               burst_left = 0;
    int               stall_mode = 0;
    int               cycle_cnt = 0;

    localparam logic [16:0] SINE_TAB [0:32] = '{
        17'd0, 17'd3216, 17'd6424, 17'd9616, 17'd12785, 17'd15924, 17'd19024, 17'd22078,
        17'd25080, 17'd28020, 17'd30893, 17'd33692, 17'd36410, 17'd39040, 17'd41576,
        17'd44011, 17'd46341, 17'd48559, 17'd50660, 17'd52639, 17'd54491, 17'd56212,
        17'd57798, 17'd59244, 17'd60547, 17'd61705, 17'd62714, 17'd63572, 17'd64277,
        17'd64827, 17'd65220, 17'd65457, 17'd65536
    };

    radial_sine_gradient_pixel_top dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [INT_W-1:0] predict_intensity(input t_pixel px);
        longint unsigned mx, my, dx, dy, d, dmax, r, q, idx, frac, s;
        mx   = ((tex_w > MAX_SIZE_DEF) ? MAX_SIZE_DEF : tex_w) >> 1;
        my   = ((tex_h > MAX_SIZE_DEF) ? MAX_SIZE_DEF : tex_h) >> 1;
        dx   = (px.col >= mx) ? px.col - mx : mx - px.col;
        dy   = (px.row >= my) ? px.row - my : my - px.row;
        d    = int_sqrt((dx * dx + dy * dy) << 16);
        dmax = int_sqrt((mx * mx + my * my) << 16);
        if (dmax == 0) return '0;
        r = (d << 16) / dmax;
        if (r >= 64'h10000) return '0;
        q    = (r >= 64'h8000) ? 64'h10000 - r : r;
        idx  = q >> 10;
        frac = q & 64'h3FF;
        if (idx >= 32) s = SINE_TAB[32];
        else s = SINE_TAB[idx] + (((SINE_TAB[idx+1] - SINE_TAB[idx]) * frac) >> 10);
        s = s >> 8;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // sender: bursts and gaps, payload held while stalled
    always @(negedge i_clk) begin
        logic take;
        t_pixel px;
        take = !i_valid || in_fired;
        if (i_rst_n && take) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                px = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_col   <= px.col;
                i_row   <= px.row;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, mode reshuffled at random from time to time
    always @(negedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt % 150 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (cycle_cnt % 7) < 3;
        endcase
    end

    always @(posedge i_clk) begin
        t_pixel px;
        logic [INT_W-1:0] want;
        in_fired = i_rst_n && i_valid && !o_stall;
        if (in_fired) begin
            px.col = i_col;
            px.row = i_row;
            intensity_q.push_back(predict_intensity(px));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (intensity_q.size() == 0) begin
                report_mismatch($sformatf("unexpected intensity beat %0d", o_intensity));
            end else begin
                want = intensity_q.pop_front();
                if (o_intensity !== want)
                    report_mismatch($sformatf("intensity %0d, expected %0d", o_intensity, want));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TEX_WIDTH) tex_w = val;
        else tex_h = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pixel_q.size() > 0 || i_valid || intensity_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(input int c, input int r);
        t_pixel px;
        px.col = COL_W'(c);
        px.row = COL_W'(r);
        pixel_q.push_back(px);
    endtask

    task automatic random_phase(input int n);
        int lim_c, lim_r;
        lim_c = (tex_w > MAX_SIZE_DEF) ? MAX_SIZE_DEF : ((tex_w < 2) ? 2 : tex_w);
        lim_r = (tex_h > MAX_SIZE_DEF) ? MAX_SIZE_DEF : ((tex_h < 2) ? 2 : tex_h);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) push_pixel($urandom_range(0, 1023),
                                                      $urandom_range(0, 1023));
            else push_pixel($urandom_range(0, lim_c - 1), $urandom_range(0, lim_r - 1));
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: corners, centre, extremes
        push_pixel(0, 0);
        push_pixel(1023, 1023);
        push_pixel(128, 128);
        push_pixel(255, 255);
        push_pixel(0, 1023);
        push_pixel(1023, 0);
        push_pixel(64, 64);
        push_pixel(682, 341);
        wait_idle();

        // flat texture: exact peak, centre and points at the largest distance
        write_reg(CFG_TEX_HEIGHT, 11'd0);
        push_pixel(64, 0);
        push_pixel(192, 0);
        push_pixel(0, 0);
        push_pixel(256, 0);
        push_pixel(128, 0);
        wait_idle();

        // degenerate sizes
        write_reg(CFG_TEX_WIDTH, 11'd1);
        write_reg(CFG_TEX_HEIGHT, 11'd1);
        push_pixel(0, 0);
        push_pixel(1023, 1023);
        push_pixel(5, 0);
        wait_idle();

        // small width and oversized height
        write_reg(CFG_TEX_WIDTH, 11'd2);
        write_reg(CFG_TEX_HEIGHT, 11'd2047);
        push_pixel(0, 512);
        push_pixel(1, 0);
        push_pixel(1, 1023);
        push_pixel(0, 256);
        wait_idle();

        random_phase(300);
        write_reg(CFG_TEX_WIDTH, 11'd1024);
        write_reg(CFG_TEX_HEIGHT, 11'd1024);
        random_phase(300);
        write_reg(CFG_TEX_WIDTH, 11'd2);
        write_reg(CFG_TEX_HEIGHT, 11'd2);
        random_phase(150);
        repeat (4) begin
            write_reg(CFG_TEX_WIDTH, CFG_W'($urandom_range(0, 2047)));
            write_reg(CFG_TEX_HEIGHT, CFG_W'($urandom_range(2, 1100)));
            random_phase(200);
        end

        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rsg_pkg.sv
rtl/core/rsg_sqrt_cell.sv
rtl/core/rsg_div_cell.sv
rtl/core/rsg_sine.sv
rtl/core/radial_sine_gradient_pixel_top.sv
dv/testbench.sv
